[design/gqr_pkg.sv]
// ----------------------------------------------------------------------------
// gqr_pkg: shared types and constants for the Givens QR decomposition block
// Payload structs, fixed-point format constants, datapath command codes and
// the controller-to-datapath command and status structs, and a rounding helper.
// ----------------------------------------------------------------------------
`default_nettype none
package gqr_pkg;

	localparam int VW       = 24;
	localparam int FRAC     = 12;
	localparam int CS_FRAC  = 30;
	localparam int CW       = 32;  // coefficient width, |c|,|s| <= 2^30
	localparam int SQW      = 48;  // x*x + y*y width
	localparam int RW       = 25;  // root width
	localparam int DIVW     = 55;  // dividend width: |x| << 30

	typedef struct packed {
		logic signed [VW-1:0] element_value;
		logic                 last_element;
	} in_item_t;

	typedef struct packed {
		logic                 which_matrix;
		logic [1:0]           row_index;
		logic [1:0]           col_index;
		logic signed [VW-1:0] result_value;
		logic                 last_result;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_IDENT = 3'd1,
		OP_SQRT  = 3'd2,
		OP_DIVC  = 3'd3,
		OP_DIVS  = 3'd4,
		OP_ROTW  = 3'd5,
		OP_ROTA  = 3'd6
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       start;
		logic       load;
		logic [1:0] ld_row;
		logic [1:0] ld_col;
		logic [1:0] pj;
		logic [1:0] pi;
		logic [1:0] pk;
		logic [1:0] rd_row;
		logic [1:0] rd_col;
		logic       rd_acc;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic both_zero;
	} dp_sts_t;

	// round |v| >> CS_FRAC ties away, signed result saturated to VW bits
	function automatic logic signed [VW-1:0] round_sat(input logic signed [57:0] v);
		logic [57:0] m;
		logic [57:0] q;
		logic signed [58:0] r;
		m = v[57] ? 58'(-v) : 58'(v);
		q = (m + 58'(1) * (58'd1 << (CS_FRAC - 1))) >> CS_FRAC;
		r = v[57] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (r > 59'sd8388607)
			return 24'sh7FFFFF;
		else if (r < -59'sd8388608)
			return 24'sh800000;
		else
			return r[VW-1:0];
	endfunction

endpackage
`default_nettype wire

[design/gqr_datapath.sv]
// ----------------------------------------------------------------------------
// gqr_datapath: matrix storage and arithmetic units
// Holds work matrix and accumulator, runs a bit-serial square root, a
// bit-serial restoring divider and a two-stage rotation multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module gqr_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gqr_pkg::dp_cmd_t              cmd,
	input  wire logic signed [gqr_pkg::VW-1:0] ld_value,
	output gqr_pkg::dp_sts_t                   sts,
	output logic signed [gqr_pkg::VW-1:0]      rd_value
);

	logic signed [gqr_pkg::VW-1:0] wm_q  [4][4];
	logic signed [gqr_pkg::VW-1:0] acc_q [4][4];
	logic signed [gqr_pkg::CW-1:0] c_q, s_q;
	logic [gqr_pkg::RW-1:0]        r_q;
	logic [gqr_pkg::SQW-1:0]       sq_n_q, sq_res_q;
	logic [5:0]                    cnt_q;
	logic                          busy_q;
	logic [gqr_pkg::DIVW-1:0]      div_rem_q, div_quo_q;
	logic [1:0]                    rot_st_q;
	logic signed [57:0]            p0_s1, p1_s1;
	logic signed [gqr_pkg::VW-1:0] a_q, b_q;

	logic signed [gqr_pkg::VW-1:0] x_w, y_w, a_w, b_w, a_op_w, b_op_w;
	logic [gqr_pkg::VW-1:0]        ax_w, ay_w;
	logic [gqr_pkg::SQW-1:0]       sq_bit_w, sq_try_w;
	logic [gqr_pkg::DIVW:0]        div_try_w;
	logic signed [gqr_pkg::CW-1:0] k0_w, k1_w;
	logic signed [gqr_pkg::CW:0]   neg_s_w;

	assign x_w  = wm_q[cmd.pj][cmd.pj];
	assign y_w  = wm_q[cmd.pi][cmd.pj];
	assign ax_w = x_w[gqr_pkg::VW-1] ? gqr_pkg::VW'(-x_w) : x_w;
	assign ay_w = y_w[gqr_pkg::VW-1] ? gqr_pkg::VW'(-y_w) : y_w;
	assign sts.both_zero = (x_w == '0) && (y_w == '0);
	assign sts.busy = busy_q;

	// one-hot square-root bit at step cnt (two bits per step)
	assign sq_bit_w = gqr_pkg::SQW'(1) << {cnt_q[4:0], 1'b0};
	assign sq_try_w = sq_res_q + sq_bit_w;
	// trial subtract with the next dividend bit shifted in
	assign div_try_w = {div_rem_q, div_quo_q[gqr_pkg::DIVW-1]}
	                 - {1'b0, {(gqr_pkg::DIVW-gqr_pkg::RW){1'b0}}, r_q};

	// rotation operands: entry pk of rows pj (a) and pi (b)
	assign a_w = (cmd.op == gqr_pkg::OP_ROTA) ? acc_q[cmd.pj][cmd.pk] : wm_q[cmd.pj][cmd.pk];
	assign b_w = (cmd.op == gqr_pkg::OP_ROTA) ? acc_q[cmd.pi][cmd.pk] : wm_q[cmd.pi][cmd.pk];
	// the i-row pass uses the operands held before the j-row write
	assign a_op_w = rot_st_q[0] ? a_q : a_w;
	assign b_op_w = rot_st_q[0] ? b_q : b_w;
	assign neg_s_w = -(gqr_pkg::CW+1)'(s_q);
	assign k0_w = rot_st_q[0] ? neg_s_w[gqr_pkg::CW-1:0] : c_q;
	assign k1_w = rot_st_q[0] ? c_q : s_q;

	assign rd_value = cmd.rd_acc ? acc_q[cmd.rd_col][cmd.rd_row] : wm_q[cmd.rd_row][cmd.rd_col];

	// sequence the iterative units and write back rotated entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			rot_st_q  <= '0;
			c_q       <= '0;
			s_q       <= '0;
			r_q       <= '0;
			sq_n_q    <= '0;
			sq_res_q  <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			p0_s1     <= '0;
			p1_s1     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++) begin
					wm_q[i][j]  <= '0;
					acc_q[i][j] <= (i == j) ? gqr_pkg::VW'(1 << gqr_pkg::FRAC) : '0;
				end
		end else begin
			if (cmd.load)
				wm_q[cmd.ld_row][cmd.ld_col] <= ld_value;
			if (cmd.start) begin
				busy_q <= 1'b1;
				unique case (cmd.op) inside
					gqr_pkg::OP_IDENT: begin
						for (int i = 0; i < 4; i++)
							for (int j = 0; j < 4; j++)
								acc_q[i][j] <= (i == j) ?
									gqr_pkg::VW'(1 << gqr_pkg::FRAC) : '0;
						busy_q <= 1'b0;
					end
					gqr_pkg::OP_SQRT: begin
						sq_n_q   <= gqr_pkg::SQW'(ax_w) * gqr_pkg::SQW'(ax_w)
						          + gqr_pkg::SQW'(ay_w) * gqr_pkg::SQW'(ay_w);
						sq_res_q <= '0;
						cnt_q    <= 6'd23;
					end
					gqr_pkg::OP_DIVC, gqr_pkg::OP_DIVS: begin
						div_quo_q <= gqr_pkg::DIVW'((cmd.op == gqr_pkg::OP_DIVC) ? ax_w : ay_w)
						             << gqr_pkg::CS_FRAC;
						div_rem_q <= gqr_pkg::DIVW'(r_q >> 1);
						cnt_q     <= 6'd55;
					end
					gqr_pkg::OP_ROTW, gqr_pkg::OP_ROTA: begin
						rot_st_q <= 2'd0;
						cnt_q    <= 6'd3;
					end
					default: busy_q <= 1'b0;
				endcase
			end else if (busy_q) begin
				unique case (cmd.op) inside
					gqr_pkg::OP_SQRT: begin
						if (sq_n_q >= sq_try_w) begin
							sq_n_q   <= sq_n_q - sq_try_w;
							sq_res_q <= (sq_res_q >> 1) + sq_bit_w;
						end else
							sq_res_q <= sq_res_q >> 1;
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							r_q    <= (sq_n_q >= sq_try_w) ?
								gqr_pkg::RW'((sq_res_q >> 1) + sq_bit_w) :
								gqr_pkg::RW'(sq_res_q >> 1);
						end
						cnt_q <= cnt_q - 6'd1;
					end
					gqr_pkg::OP_DIVC, gqr_pkg::OP_DIVS: begin
						// rounded quotient: r/2, pre-loaded in the remainder, is first added to the dividend
						if (cnt_q == 6'd55) begin
							div_quo_q <= div_quo_q + div_rem_q;
							div_rem_q <= '0;
							cnt_q     <= 6'd54;
						end else begin
							if (!div_try_w[gqr_pkg::DIVW]) begin
								div_rem_q <= div_try_w[gqr_pkg::DIVW-1:0];
							end else
								div_rem_q <= {div_rem_q[gqr_pkg::DIVW-2:0],
									div_quo_q[gqr_pkg::DIVW-1]};
							div_quo_q <= {div_quo_q[gqr_pkg::DIVW-2:0],
								~div_try_w[gqr_pkg::DIVW]};
							if (cnt_q == '0) begin
								busy_q <= 1'b0;
								if (cmd.op == gqr_pkg::OP_DIVC)
									c_q <= x_w[gqr_pkg::VW-1] ?
										-gqr_pkg::CW'({div_quo_q[gqr_pkg::DIVW-2:0],
											~div_try_w[gqr_pkg::DIVW]}) :
										gqr_pkg::CW'({div_quo_q[gqr_pkg::DIVW-2:0],
											~div_try_w[gqr_pkg::DIVW]});
								else
									s_q <= y_w[gqr_pkg::VW-1] ?
										-gqr_pkg::CW'({div_quo_q[gqr_pkg::DIVW-2:0],
											~div_try_w[gqr_pkg::DIVW]}) :
										gqr_pkg::CW'({div_quo_q[gqr_pkg::DIVW-2:0],
											~div_try_w[gqr_pkg::DIVW]});
							end
							cnt_q <= cnt_q - 6'd1;
						end
					end
					gqr_pkg::OP_ROTW, gqr_pkg::OP_ROTA: begin
						// products for one output row, then round and write
						unique case (rot_st_q) inside
							2'd0, 2'd1: begin
								p0_s1 <= 58'(k0_w * a_op_w);
								p1_s1 <= 58'(k1_w * b_op_w);
								if (!rot_st_q[0]) begin
									a_q <= a_w;
									b_q <= b_w;
								end
								rot_st_q <= rot_st_q | 2'd2;
							end
							default: begin
								if (cmd.op == gqr_pkg::OP_ROTA) begin
									if (rot_st_q[0])
										acc_q[cmd.pi][cmd.pk] <= gqr_pkg::round_sat(p0_s1 + p1_s1);
									else
										acc_q[cmd.pj][cmd.pk] <= gqr_pkg::round_sat(p0_s1 + p1_s1);
								end else begin
									if (rot_st_q[0])
										wm_q[cmd.pi][cmd.pk] <= gqr_pkg::round_sat(p0_s1 + p1_s1);
									else
										wm_q[cmd.pj][cmd.pk] <= gqr_pkg::round_sat(p0_s1 + p1_s1);
								end
								rot_st_q <= 2'd1;
								if (rot_st_q[0]) busy_q <= 1'b0;
							end
						endcase
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[design/gqr_controller.sv]
// ----------------------------------------------------------------------------
// gqr_controller: sequencing of load, rotations and output stream
// Walks the column/row/entry loops and issues datapath commands, then emits
// Q and R elements on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
module gqr_controller #(
	parameter int MAX_ROWS = 4,
	parameter int MAX_COLS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_idx,
	input  wire logic [2:0]           cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_last,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      out_which,
	output logic [1:0]                out_row,
	output logic [1:0]                out_col,
	output logic                      out_last,
	output gqr_pkg::dp_cmd_t          cmd,
	input  wire gqr_pkg::dp_sts_t     sts
);

	typedef enum logic [5:0] {
		S_LOAD = 6'b000001,
		S_PREP = 6'b000010,
		S_ISSUE = 6'b000100,
		S_WAIT = 6'b001000,
		S_EMIT = 6'b010000,
		S_NEXT = 6'b100000
	} state_t;

	state_t     state_q;
	logic [2:0] rows_q, cols_q, m_w, n_w;
	logic [4:0] pos_q;
	logic [1:0] j_q, i_q, k_q, er_q, ec_q;
	logic       eacc_q;
	gqr_pkg::dp_op_t op_q;
	logic       start_q;

	assign m_w = (rows_q < 3'd2) ? 3'd2 : (rows_q > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : rows_q;
	assign n_w = (cols_q < 3'd1) ? 3'd1 : (cols_q > 3'(MAX_COLS)) ? 3'(MAX_COLS) : cols_q;

	logic [4:0] mn_w;
	logic [4:0] ld_r_w, ld_c_w;
	assign mn_w = 5'(m_w * n_w);
	always_comb begin
		ld_r_w = '0;
		ld_c_w = pos_q;
		for (int t = 0; t < 4; t++)
			if (ld_c_w >= 5'(n_w)) begin
				ld_c_w = ld_c_w - 5'(n_w);
				ld_r_w = ld_r_w + 5'd1;
			end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_EMIT);
	assign out_which = ~eacc_q;
	assign out_row   = er_q;
	assign out_col   = ec_q;
	assign out_last  = ~eacc_q && (3'(er_q) == m_w - 3'd1) && (3'(ec_q) == n_w - 3'd1);

	always_comb begin
		cmd = '0;
		cmd.op     = op_q;
		cmd.start  = start_q;
		cmd.load   = in_valid && in_ready && (pos_q < mn_w);
		cmd.ld_row = ld_r_w[1:0];
		cmd.ld_col = ld_c_w[1:0];
		cmd.pj     = j_q;
		cmd.pi     = i_q;
		cmd.pk     = k_q;
		cmd.rd_row = er_q;
		cmd.rd_col = ec_q;
		cmd.rd_acc = eacc_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 3'd4;
			cols_q <= 3'd4;
		end else if (cfg_we) begin
			if (!cfg_idx) rows_q <= cfg_data;
			else          cols_q <= cfg_data;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pos_q   <= '0;
			op_q    <= gqr_pkg::OP_NONE;
			start_q <= 1'b0;
			{j_q, i_q, k_q, er_q, ec_q} <= '0;
			eacc_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_LOAD: if (in_valid) begin
					if (pos_q < mn_w) pos_q <= pos_q + 5'd1;
					if (in_last) begin
						op_q <= gqr_pkg::OP_IDENT;
						start_q <= 1'b1;
						j_q <= '0;
						i_q <= 2'd1;
						state_q <= S_WAIT;
					end
				end
				S_PREP: begin
					// choose next rotation or go emit
					if (3'(j_q) >= n_w || 3'(j_q) >= m_w - 3'd1) begin
						state_q <= S_EMIT;
						eacc_q <= 1'b1; er_q <= '0; ec_q <= '0;
					end else if (3'(i_q) >= m_w) begin
						j_q <= j_q + 2'd1;
						i_q <= j_q + 2'd2;
					end else if (sts.both_zero) begin
						i_q <= i_q + 2'd1;
						if (i_q == 2'd3) begin j_q <= j_q + 2'd1; i_q <= j_q + 2'd2; end
					end else begin
						op_q <= gqr_pkg::OP_SQRT; start_q <= 1'b1; state_q <= S_WAIT;
					end
				end
				S_ISSUE: begin
					start_q <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: if (!start_q && !sts.busy) begin
					unique case (op_q)
						gqr_pkg::OP_IDENT: state_q <= S_PREP;
						gqr_pkg::OP_SQRT: begin op_q <= gqr_pkg::OP_DIVC; state_q <= S_ISSUE; end
						gqr_pkg::OP_DIVC: begin op_q <= gqr_pkg::OP_DIVS; state_q <= S_ISSUE; end
						gqr_pkg::OP_DIVS: begin
							op_q <= gqr_pkg::OP_ROTW; k_q <= '0; state_q <= S_ISSUE;
						end
						gqr_pkg::OP_ROTW: begin
							if (3'(k_q) == n_w - 3'd1) begin
								op_q <= gqr_pkg::OP_ROTA; k_q <= '0;
							end else k_q <= k_q + 2'd1;
							state_q <= S_ISSUE;
						end
						gqr_pkg::OP_ROTA: begin
							if (3'(k_q) == m_w - 3'd1) begin
								state_q <= S_PREP;
								if (i_q == 2'd3) begin j_q <= j_q + 2'd1; i_q <= j_q + 2'd2; end
								else i_q <= i_q + 2'd1;
							end else begin
								k_q <= k_q + 2'd1; state_q <= S_ISSUE;
							end
						end
						default: state_q <= S_PREP;
					endcase
				end
				S_EMIT: if (out_ready) state_q <= S_NEXT;
				S_NEXT: begin
					state_q <= S_EMIT;
					if (eacc_q) begin
						if (3'(ec_q) == m_w - 3'd1) begin
							ec_q <= '0;
							if (3'(er_q) == m_w - 3'd1) begin er_q <= '0; eacc_q <= 1'b0; end
							else er_q <= er_q + 2'd1;
						end else ec_q <= ec_q + 2'd1;
					end else begin
						if (3'(ec_q) == n_w - 3'd1) begin
							ec_q <= '0;
							if (3'(er_q) == m_w - 3'd1) begin
								state_q <= S_LOAD; pos_q <= '0;
							end else er_q <= er_q + 2'd1;
						end else ec_q <= ec_q + 2'd1;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/givens_qr_decomposition_top.sv]
// After the last element each rotation runs a square root, two divides and
// the rotation of every entry of both rows; each output beat is followed by
// an S_NEXT step before the next. Loading takes one element per cycle.
// One matrix at a time; the next load starts after the final R beat.
// Asynchronous active-low reset clears control, loads identity into the
// accumulator and sets 4 rows by 4 columns.
// ----------------------------------------------------------------------------
// givens_qr_decomposition_top: Givens rotation QR decomposition
// Controller and datapath joined by a command and status struct.
// ----------------------------------------------------------------------------
`default_nettype none
module givens_qr_decomposition_top #(
	parameter int MAX_ROWS = 4,
	parameter int MAX_COLS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_idx,
	input  wire logic [2:0]           cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire gqr_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output gqr_pkg::out_item_t        out_data
);

	gqr_pkg::dp_cmd_t cmd;
	gqr_pkg::dp_sts_t sts;

	gqr_controller #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_valid, .in_ready, .in_last(in_data.last_element),
		.out_valid, .out_ready,
		.out_which(out_data.which_matrix), .out_row(out_data.row_index),
		.out_col(out_data.col_index), .out_last(out_data.last_result),
		.cmd, .sts
	);

	gqr_datapath u_dp (
		.clk, .arst_n, .cmd, .ld_value(in_data.element_value),
		.sts, .rd_value(out_data.result_value)
	);

endmodule
`default_nettype wire

[design/gqr_checker.sv]
// ----------------------------------------------------------------------------
// gqr_checker: port-level checks for the QR block
// Watches handshakes and output ordering on the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module gqr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire gqr_pkg::out_item_t out_data
);

	// output and input never open together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("in and out both open");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// after the last R beat the block returns to loading
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_result |=> ##1 in_ready)
		else $error("no return to load");

	// last flag only on R
	a_lastr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_result |-> out_data.which_matrix)
		else $error("last on Q");

endmodule

bind givens_qr_decomposition_top gqr_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

[verif/givens_qr_decomposition_top_test.sv]
// ----------------------------------------------------------------------------
// givens_qr_decomposition_top_test: self-checking bench for the Givens QR block
// Streams matrices under several row/column settings, predicts Q and R with a
// fixed-point Givens model of its own and checks every output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module givens_qr_decomposition_top_test;

	localparam int TIMEOUT_CYCLES = 10000;
	localparam int RANDOM_ITEMS   = 460;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_idx = 1'b0;
	logic [2:0] cfg_data = 3'd0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	gqr_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	gqr_pkg::out_item_t out_data;

	givens_qr_decomposition_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	longint    mat [4][4];
	longint    acc [4][4];
	int        load_pos = 0;
	logic [2:0] rows_reg = 3'd4;
	logic [2:0] cols_reg = 3'd4;
	gqr_pkg::out_item_t qr_expected[$];
	gqr_pkg::in_item_t  pending_items[$];
	int        errors = 0;
	int        items_sent = 0;

	// generator view of entries written since reset
	bit        gen_written [4][4];

	function automatic int used_rows();
		return (rows_reg < 2) ? 2 : (rows_reg > 4) ? 4 : int'(rows_reg);
	endfunction

	function automatic int used_cols();
		return (cols_reg < 1) ? 1 : (cols_reg > 4) ? 4 : int'(cols_reg);
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint rot_coef(longint num, longint unsigned r);
		longint unsigned q;
		q = ((magnitude(num) << gqr_pkg::CS_FRAC) + r / 2) / r;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint rotate(longint ka, longint a, longint kb, longint b);
		longint sum, v;
		longint unsigned q;
		sum = ka * a + kb * b;
		q = (magnitude(sum) + (64'd1 << (gqr_pkg::CS_FRAC - 1))) >> gqr_pkg::CS_FRAC;
		v = (sum < 0) ? -longint'(q) : longint'(q);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v;
	endfunction

	// store one element; on the last flag rotate and queue Q then R
	task automatic qr_predict(gqr_pkg::in_item_t it);
		int m, n, i, j, k;
		longint x, y, c, s, a, b;
		longint unsigned r;
		gqr_pkg::out_item_t o;
		m = used_rows();
		n = used_cols();
		if (load_pos < m * n) begin
			mat[load_pos / n][load_pos % n] = longint'(signed'(it.element_value));
			load_pos++;
		end
		if (!it.last_element) return;
		for (i = 0; i < 4; i++)
			for (j = 0; j < 4; j++)
				acc[i][j] = (i == j) ? 4096 : 0;
		for (j = 0; j < n; j++)
			for (i = j + 1; i < m; i++) begin
				x = mat[j][j];
				y = mat[i][j];
				if (x == 0 && y == 0) continue;
				r = int_sqrt(magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y));
				c = rot_coef(x, r);
				s = rot_coef(y, r);
				for (k = 0; k < n; k++) begin
					a = mat[j][k];
					b = mat[i][k];
					mat[j][k] = rotate(c, a, s, b);
					mat[i][k] = rotate(-s, a, c, b);
				end
				for (k = 0; k < m; k++) begin
					a = acc[j][k];
					b = acc[i][k];
					acc[j][k] = rotate(c, a, s, b);
					acc[i][k] = rotate(-s, a, c, b);
				end
			end
		load_pos = 0;
		for (i = 0; i < m; i++)
			for (j = 0; j < m; j++) begin
				o.which_matrix = 1'b0;
				o.row_index    = i[1:0];
				o.col_index    = j[1:0];
				o.result_value = acc[j][i][gqr_pkg::VW-1:0];
				o.last_result  = 1'b0;
				qr_expected.push_back(o);
			end
		for (i = 0; i < m; i++)
			for (j = 0; j < n; j++) begin
				o.which_matrix = 1'b1;
				o.row_index    = i[1:0];
				o.col_index    = j[1:0];
				o.result_value = mat[i][j][gqr_pkg::VW-1:0];
				o.last_result  = (i == m - 1 && j == n - 1);
				qr_expected.push_back(o);
			end
	endtask

	function automatic logic [gqr_pkg::VW-1:0] pick_value();
		case ($urandom_range(0, 9)) inside
			0: return '0;
			1: return 24'h7FFFFF;
			2: return 24'h800000;
			3, 4, 5: return 24'($signed($urandom_range(0, 32768)) - 16384);
			default: return 24'($urandom);
		endcase
	endfunction

	// queue one matrix: kind 0 full, 1 overlong, 2 early last, 3 fixed value
	task automatic queue_matrix(int kind, logic [gqr_pkg::VW-1:0] fixed_val);
		int m, n, cnt, idx;
		bit all_written;
		gqr_pkg::in_item_t it;
		m = used_rows();
		n = used_cols();
		all_written = 1'b1;
		for (int i = 0; i < m; i++)
			for (int j = 0; j < n; j++)
				if (!gen_written[i][j]) all_written = 1'b0;
		cnt = m * n;
		if (kind == 1) cnt = m * n + $urandom_range(1, 3);
		if (kind == 2 && all_written && m * n > 1) cnt = $urandom_range(1, m * n - 1);
		for (idx = 0; idx < cnt; idx++) begin
			it.element_value = (kind == 3) ? fixed_val : pick_value();
			it.last_element  = (idx == cnt - 1);
			if (idx < m * n) gen_written[idx / n][idx % n] = 1'b1;
			pending_items.push_back(it);
			items_sent++;
		end
	endtask

	task automatic write_reg(bit idx, logic [2:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx) cols_reg = val;
		else rows_reg = val;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || qr_expected.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) qr_predict(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= pending_items.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: own stall pattern plus a requested long hold-off
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_cnt  <= 2000;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// check each output beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (qr_expected.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
				errors++;
			end else begin
				gqr_pkg::out_item_t e;
				e = qr_expected.pop_front();
				if (out_data.which_matrix !== e.which_matrix || out_data.row_index !== e.row_index ||
				    out_data.col_index !== e.col_index || out_data.result_value !== e.result_value ||
				    out_data.last_result !== e.last_result) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= TIMEOUT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		foreach (mat[i, j]) mat[i][j] = 0;
		foreach (acc[i, j]) acc[i][j] = (i == j) ? 4096 : 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset size, extremes, zero matrix, early last, overlong
		queue_matrix(3, 24'h7FFFFF);
		queue_matrix(3, 24'h800000);
		queue_matrix(3, 24'h000000);
		queue_matrix(0, '0);
		queue_matrix(2, '0);
		queue_matrix(1, '0);
		drain();
		write_reg(1'b0, 3'd2);
		write_reg(1'b1, 3'd1);
		queue_matrix(3, 24'h000000);
		queue_matrix(0, '0);
		drain();
		write_reg(1'b0, 3'd7);
		write_reg(1'b1, 3'd0);
		queue_matrix(0, '0);
		drain();
		write_reg(1'b0, 3'd0);
		write_reg(1'b1, 3'd7);
		queue_matrix(0, '0);
		drain();

		// random phases
		while (items_sent < RANDOM_ITEMS) begin
			int kind;
			write_reg(1'b0, 3'($urandom_range(0, 7)));
			write_reg(1'b1, 3'($urandom_range(0, 7)));
			for (int k = 0; k < 6; k++) begin
				kind = $urandom_range(0, 9);
				queue_matrix((kind < 7) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3,
				             (kind == 9) ? 24'h0 : 24'h0);
			end
			if (hold_requests == 0 && items_sent > RANDOM_ITEMS / 2) hold_requests++;
			drain();
		end

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
